/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PMI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pmi assertion failed");

// checked on every edge, reset included
`define PMI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pmi assertion failed");

`endif

/* src/pmi_pkg.sv */
package pmi_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES      = 3;

    // quotient bits of |f|*dt/m, one divider stage per bit
    localparam int DIV_BITS = 2 * WORD_W - 1;
    localparam int STEP_W   = 41;
    localparam logic [STEP_W-1:0] STEP_CLAMP = {1'b1, {(STEP_W-1){1'b0}}};

    localparam int LANE_LAT  = DIV_BITS + 4;
    localparam int MERGE_LAT = 6;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam int CFG_IDX_W = 4;
    localparam logic [WORD_W-1:0] TIME_STEP_RST    = 32'h0001_0000;
    localparam logic [WORD_W-1:0] ENERGY_SCALE_RST = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP    = 4'd0,
        REG_ENERGY_SCALE = 4'd1
    } cfg_reg_t;

    localparam logic OP_VERLET = 1'b0;
    localparam logic OP_EULER  = 1'b1;

    typedef logic [NUM_AXES-1:0][WORD_W-1:0] vec3_t;

    typedef struct packed {
        logic              op;
        logic              fneg;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] vel;
        logic [WORD_W-1:0] mass;
    } lane_side_t;

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        r = x[WORD_W-1] ? (~x + 32'd1) : x;
        return r;
    endfunction

    // signed 66-bit value clamped to signed 32 bits
    function automatic logic [WORD_W-1:0] sat32(input logic [65:0] x);
        logic [WORD_W-1:0] r;
        if (x[65:31] == '0 || x[65:31] == '1) begin
            r = x[31:0];
        end else if (x[65]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [65:0] sext66(input logic [WORD_W-1:0] x);
        logic [65:0] r;
        r = {{34{x[WORD_W-1]}}, x};
        return r;
    endfunction

endpackage

/* src/pmi_lane.sv */
module pmi_lane #(
    parameter int FRAC_BITS = pmi_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] time_step,
    input  logic        op,
    input  logic [31:0] pos,
    input  logic [31:0] vel,
    input  logic [31:0] force_in,
    input  logic [31:0] mass,
    output logic [31:0] new_pos,
    output logic [31:0] new_vel,
    output logic [31:0] mass_out
);

    localparam int DB = pmi_pkg::DIV_BITS;
    localparam int SW = pmi_pkg::STEP_W;

    // stage a: |f| * dt
    logic [63:0]         a_prod;
    logic [DB-1:0]       a_prod_reg;
    pmi_pkg::lane_side_t a_side_reg;

    assign a_prod = {32'b0, pmi_pkg::mag32(force_in)} * {32'b0, time_step};

    always_ff @(posedge aclk) begin
        if (en) begin
            a_prod_reg      <= a_prod[DB-1:0];
            a_side_reg.op   <= op;
            a_side_reg.fneg <= force_in[31];
            a_side_reg.pos  <= pos;
            a_side_reg.vel  <= vel;
            a_side_reg.mass <= mass;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [31:0]         rem_reg  [DB];
    logic [DB-1:0]       nq_reg   [DB];
    pmi_pkg::lane_side_t side_reg [DB];

    for (genvar k = 0; k < DB; k++) begin : g_div
        logic [31:0]         rem_in;
        logic [DB-1:0]       nq_in;
        pmi_pkg::lane_side_t side_in;
        logic [32:0]         trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign nq_in   = a_prod_reg;
            assign side_in = a_side_reg;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, nq_in[DB-1]};
        assign ge    = trial >= {1'b0, side_in.mass};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? 32'(trial - {1'b0, side_in.mass}) : trial[31:0];
                nq_reg[k]   <= {nq_in[DB-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    // stage b: first velocity update
    pmi_pkg::lane_side_t q_side;
    logic [DB-1:0]       q_val;
    logic [DB-1:0]       q_eff;
    logic [SW-1:0]       step;
    logic [65:0]         vsum;
    logic                mzero;
    logic [31:0]         b_v1_reg;
    logic [SW-1:0]       b_step_reg;
    pmi_pkg::lane_side_t b_side_reg;

    assign q_side = side_reg[DB-1];
    assign q_val  = nq_reg[DB-1];
    assign mzero  = q_side.mass == '0;
    assign q_eff  = (q_side.op == pmi_pkg::OP_EULER) ? q_val : (q_val >> 1);
    assign step   = (q_eff > DB'(pmi_pkg::STEP_CLAMP)) ? pmi_pkg::STEP_CLAMP : q_eff[SW-1:0];
    assign vsum   = q_side.fneg ? pmi_pkg::sext66(q_side.vel) - {25'b0, step}
                                : pmi_pkg::sext66(q_side.vel) + {25'b0, step};

    always_ff @(posedge aclk) begin
        if (en) begin
            b_v1_reg   <= mzero ? q_side.vel : pmi_pkg::sat32(vsum);
            b_step_reg <= step;
            b_side_reg <= q_side;
        end
    end

    // stage c: |v| * dt
    logic [63:0]         c_d;
    logic [63:0]         c_d_reg;
    logic [31:0]         c_v1_reg;
    logic [SW-1:0]       c_step_reg;
    pmi_pkg::lane_side_t c_side_reg;

    assign c_d = {32'b0, pmi_pkg::mag32(b_v1_reg)} * {32'b0, time_step};

    always_ff @(posedge aclk) begin
        if (en) begin
            c_d_reg    <= c_d;
            c_v1_reg   <= b_v1_reg;
            c_step_reg <= b_step_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // stage d: position move and, for Verlet, second half step
    logic [63:0] move;
    logic [65:0] psum;
    logic [65:0] v2sum;
    logic        c_mzero;
    logic        c_verlet;
    logic [31:0] d_pos_reg;
    logic [31:0] d_vel_reg;
    logic [31:0] d_mass_reg;

    assign move     = c_d_reg >> FRAC_BITS;
    assign c_mzero  = c_side_reg.mass == '0;
    assign c_verlet = c_side_reg.op == pmi_pkg::OP_VERLET;
    assign psum     = c_v1_reg[31] ? pmi_pkg::sext66(c_side_reg.pos) - {2'b0, move}
                                   : pmi_pkg::sext66(c_side_reg.pos) + {2'b0, move};
    assign v2sum    = c_side_reg.fneg ? pmi_pkg::sext66(c_v1_reg) - {25'b0, c_step_reg}
                                      : pmi_pkg::sext66(c_v1_reg) + {25'b0, c_step_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            d_pos_reg  <= (c_verlet && c_mzero) ? c_side_reg.pos : pmi_pkg::sat32(psum);
            d_vel_reg  <= (c_verlet && !c_mzero) ? pmi_pkg::sat32(v2sum) : c_v1_reg;
            d_mass_reg <= c_side_reg.mass;
        end
    end

    assign new_pos  = d_pos_reg;
    assign new_vel  = d_vel_reg;
    assign mass_out = d_mass_reg;

endmodule

/* src/pmi_merge.sv */
module pmi_merge #(
    parameter int FRAC_BITS = pmi_pkg::FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [31:0]    energy_scale,
    input  logic [31:0]    mass,
    input  pmi_pkg::vec3_t pos,
    input  pmi_pkg::vec3_t vel,
    output pmi_pkg::vec3_t new_pos,
    output pmi_pkg::vec3_t new_vel,
    output logic [31:0]    kinetic_energy
);

    localparam int ML = pmi_pkg::MERGE_LAT;
    localparam int SW = 64 - FRAC_BITS;

    // position and velocity ride alongside the energy path
    pmi_pkg::vec3_t pos_reg [ML];
    pmi_pkg::vec3_t vel_reg [ML];

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= pos;
            vel_reg[0] <= vel;
            for (int i = 1; i < ML; i++) begin
                pos_reg[i] <= pos_reg[i-1];
                vel_reg[i] <= vel_reg[i-1];
            end
        end
    end

    // k1: squares per lane
    logic [2:0][63:0] sq;
    logic [2:0][63:0] sq_reg;
    logic [31:0]      m1_reg;

    for (genvar i = 0; i < 3; i++) begin : g_sq
        assign sq[i] = {32'b0, pmi_pkg::mag32(vel[i])} * {32'b0, pmi_pkg::mag32(vel[i])};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq;
            m1_reg <= mass;
        end
    end

    // k2: sum of squares, scaled back to q format
    logic [63:0]   sum;
    logic [SW-1:0] s_reg;
    logic [31:0]   m2_reg;

    assign sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg  <= sum[63:FRAC_BITS];
            m2_reg <= m1_reg;
        end
    end

    // k3: mass * s as two partial products
    logic [63:0]   pl;
    logic [SW-1:0] ph;
    logic [63:0]   pl_reg;
    logic [SW-1:0] ph_reg;

    assign pl = {32'b0, m2_reg} * {32'b0, s_reg[31:0]};
    assign ph = {{(SW-32){1'b0}}, m2_reg} * {32'b0, s_reg[SW-1:32]};

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg <= pl;
            ph_reg <= ph;
        end
    end

    // k4: recombine, shift, clamp to 64 bits
    logic [95:0] p1;
    logic [63:0] e1;
    logic [63:0] e1_reg;

    assign p1 = {32'b0, pl_reg} + {{FRAC_BITS{1'b0}}, ph_reg, 32'b0};
    assign e1 = (p1[95:64+FRAC_BITS] != '0) ? '1 : p1[63+FRAC_BITS:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg <= e1;
        end
    end

    // k5: e1 * energy_scale as two partial products
    logic [63:0] ql;
    logic [63:0] qh;
    logic [63:0] ql_reg;
    logic [63:0] qh_reg;

    assign ql = {32'b0, e1_reg[31:0]} * {32'b0, energy_scale};
    assign qh = {32'b0, e1_reg[63:32]} * {32'b0, energy_scale};

    always_ff @(posedge aclk) begin
        if (en) begin
            ql_reg <= ql;
            qh_reg <= qh;
        end
    end

    // k6: recombine, halve, clamp to 32 bits
    logic [95:0] p2;
    logic [63:0] e2;
    logic [31:0] ke;
    logic [31:0] ke_reg;

    assign p2 = {32'b0, ql_reg} + {qh_reg, 32'b0};
    assign e2 = (p2[95:64+FRAC_BITS] != '0) ? '1 : p2[63+FRAC_BITS:FRAC_BITS];
    assign ke = (e2[63:33] != '0) ? 32'hFFFF_FFFF : e2[32:1];

    always_ff @(posedge aclk) begin
        if (en) begin
            ke_reg <= ke;
        end
    end

    assign new_pos        = pos_reg[ML-1];
    assign new_vel        = vel_reg[ML-1];
    assign kinetic_energy = ke_reg;

endmodule

/* src/particle_motion_integrator_top.sv */
// Velocity Verlet / Euler particle integrator in signed Q16.16 (FRAC_BITS
// fractional bits). One particle is taken per clock and one result leaves per
// clock while the output is not stalled; each result passes first through the
// per-axis lanes, built around a 63-stage pipelined divider for dt*F/m, and
// then through the kinetic energy stage. Three lanes handle x, y and z side
// by side. When the output is stalled the whole pipeline holds and s_ready
// drops. time_step and energy_scale are written through the cfg port (index 0
// and 1, both reset to 1.0) and must only change while no beat is in flight.
`include "assert_macros.svh"

module particle_motion_integrator_top #(
    parameter int FRAC_BITS = pmi_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pmi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [31:0]                   s_pos_x,
    input  logic [31:0]                   s_pos_y,
    input  logic [31:0]                   s_pos_z,
    input  logic [31:0]                   s_vel_x,
    input  logic [31:0]                   s_vel_y,
    input  logic [31:0]                   s_vel_z,
    input  logic [31:0]                   s_force_x,
    input  logic [31:0]                   s_force_y,
    input  logic [31:0]                   s_force_z,
    input  logic [31:0]                   s_mass,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_new_pos_x,
    output logic [31:0]                   m_new_pos_y,
    output logic [31:0]                   m_new_pos_z,
    output logic [31:0]                   m_new_vel_x,
    output logic [31:0]                   m_new_vel_y,
    output logic [31:0]                   m_new_vel_z,
    output logic [31:0]                   m_kinetic_energy
);

    localparam int TL = pmi_pkg::TOTAL_LAT;

    // configuration
    logic [31:0] time_step_reg;
    logic [31:0] energy_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg    <= pmi_pkg::TIME_STEP_RST;
            energy_scale_reg <= pmi_pkg::ENERGY_SCALE_RST;
        end else if (cfg_valid) begin
            unique case (pmi_pkg::cfg_reg_t'(cfg_index))
                pmi_pkg::REG_TIME_STEP:    time_step_reg    <= cfg_data;
                pmi_pkg::REG_ENERGY_SCALE: energy_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // beat tracking through the pipeline
    logic [TL-1:0] vld_reg;
    logic          adv;

    assign adv     = m_ready || !vld_reg[TL-1];
    assign s_ready = adv;
    assign m_valid = vld_reg[TL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TL-2:0], s_valid};
        end
    end

    // per-axis lanes
    pmi_pkg::vec3_t pos_in;
    pmi_pkg::vec3_t vel_in;
    pmi_pkg::vec3_t frc_in;
    pmi_pkg::vec3_t lane_pos;
    pmi_pkg::vec3_t lane_vel;
    logic [31:0]    lane_mass;

    assign pos_in = {s_pos_z, s_pos_y, s_pos_x};
    assign vel_in = {s_vel_z, s_vel_y, s_vel_x};
    assign frc_in = {s_force_z, s_force_y, s_force_x};

    for (genvar i = 0; i < pmi_pkg::NUM_AXES; i++) begin : g_lane
        if (i == 0) begin : g_mass
            pmi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .aclk      (aclk),
                .en        (adv),
                .time_step (time_step_reg),
                .op        (s_op),
                .pos       (pos_in[i]),
                .vel       (vel_in[i]),
                .force_in  (frc_in[i]),
                .mass      (s_mass),
                .new_pos   (lane_pos[i]),
                .new_vel   (lane_vel[i]),
                .mass_out  (lane_mass)
            );
        end else begin : g_plain
            pmi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .aclk      (aclk),
                .en        (adv),
                .time_step (time_step_reg),
                .op        (s_op),
                .pos       (pos_in[i]),
                .vel       (vel_in[i]),
                .force_in  (frc_in[i]),
                .mass      (s_mass),
                .new_pos   (lane_pos[i]),
                .new_vel   (lane_vel[i]),
                .mass_out  ()
            );
        end
    end

    // energy and output alignment
    pmi_pkg::vec3_t out_pos;
    pmi_pkg::vec3_t out_vel;

    pmi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk           (aclk),
        .en             (adv),
        .energy_scale   (energy_scale_reg),
        .mass           (lane_mass),
        .pos            (lane_pos),
        .vel            (lane_vel),
        .new_pos        (out_pos),
        .new_vel        (out_vel),
        .kinetic_energy (m_kinetic_energy)
    );

    assign m_new_pos_x = out_pos[0];
    assign m_new_pos_y = out_pos[1];
    assign m_new_pos_z = out_pos[2];
    assign m_new_vel_x = out_vel[0];
    assign m_new_vel_y = out_vel[1];
    assign m_new_vel_z = out_vel[2];

    `PMI_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid)
    `PMI_ASSERT(a_accept_enters, aclk, aresetn, s_valid && s_ready |=> vld_reg[0])
    `PMI_ASSERT(a_stall_holds, aclk, aresetn, !s_ready |=> $stable(vld_reg))
    `PMI_ASSERT(a_lane_to_merge, aclk, aresetn,
        adv && vld_reg[pmi_pkg::LANE_LAT-1] |=> vld_reg[pmi_pkg::LANE_LAT])

endmodule
